FILE: rtl/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties package
// Shared widths, register codes, result kinds, item structs and the back-end
// state encoding for the polygon pose properties block.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int COORD_W     = 32;
   localparam int POSE_W      = 18;
   localparam int VALUE_W     = 48;
   localparam int AREA_W      = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_X     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_Y     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_ANGLE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_ANGLE = 2'd3;

   // pose after reset: origin, angle zero (cosine 1.0 in Q2.16)
   localparam logic signed [POSE_W-1:0] COS_RESET = 18'sd65536;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      KIND_VERTEX     = 3'd0,
      KIND_EDGE       = 3'd1,
      KIND_CENTROID   = 3'd2,
      KIND_BOX_ORIGIN = 3'd3,
      KIND_BOX_SIZE   = 3'd4,
      KIND_AREA       = 3'd5
   } kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic                      final_vertex;
   } vertex_in_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [VALUE_W-1:0] value_x;
      logic signed [VALUE_W-1:0] value_y;
      logic                      run_end;
   } result_type;

   // placed vertex handed from the front end to the back end
   typedef struct packed {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] local_x;
      logic signed [COORD_W-1:0] local_y;
      logic                      final_vertex;
   } world_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [POSE_W-1:0]  cos_angle;
      logic signed [POSE_W-1:0]  sin_angle;
   } pose_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VERT,
      ST_EDGE,
      ST_AREA1,
      ST_AREA2,
      ST_UPDATE,
      ST_FIN_START,
      ST_CLOSE,
      ST_CACC1,
      ST_CACC2,
      ST_CMAG,
      ST_CROUND,
      ST_CENT,
      ST_ORIGIN,
      ST_SIZE,
      ST_AREA
   } back_state_type;

endpackage

FILE: rtl/ppp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties stream channel
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface ppp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ppp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties front end
// Holds the pose registers, accepts local vertices and places them in the
// world in a three-stage pipeline (capture, multiply, round/offset/saturate).
// ----------------------------------------------------------------------------
module ppp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ppp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   ppp_stream_if.sink                          req_if,
   output logic                                push_valid,
   input  logic                                push_ready,
   output ppp_pkg::world_item_type             push_data
);
   import ppp_pkg::*;

   localparam int PROD_W = COORD_W + POSE_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int FRAC_W = 16;

   pose_type pose_ff, pose_in;

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   vertex_in_type             s1_ff;
   logic signed [COORD_W-1:0] s2_lx_ff, s2_ly_ff;
   logic                      s2_last_ff;
   logic signed [PROD_W-1:0]  p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   world_item_type            s3_ff, s3_in;
   logic                      advance;
   logic signed [SUM_W-1:0]   sum_x, sum_y;

   function automatic logic signed [SUM_W-1:0] widen(input logic signed [PROD_W-1:0] p);
      widen = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // clamp a shifted sum to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SUM_W-FRAC_W-1:0] v);
      logic signed [SUM_W-FRAC_W-1:0] hi, lo;
      hi = {{(SUM_W-FRAC_W-COORD_W){1'b0}}, COORD_MAX};
      lo = {{(SUM_W-FRAC_W-COORD_W){1'b1}}, COORD_MIN};
      if (v > hi) begin
         sat_coord = COORD_MAX;
      end else if (v < lo) begin
         sat_coord = COORD_MIN;
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

   // write pose registers
   always_comb begin
      pose_in = pose_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POS_X:     pose_in.pos_x     = csr_wdata;
            CSR_POS_Y:     pose_in.pos_y     = csr_wdata;
            CSR_COS_ANGLE: pose_in.cos_angle = csr_wdata[POSE_W-1:0];
            CSR_SIN_ANGLE: pose_in.sin_angle = csr_wdata[POSE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_ff.pos_x     <= '0;
         pose_ff.pos_y     <= '0;
         pose_ff.cos_angle <= COS_RESET;
         pose_ff.sin_angle <= '0;
      end else begin
         pose_ff <= pose_in;
      end
   end

   // advance all stages together unless the last one is blocked
   assign advance      = !s3_valid_ff || push_ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_if.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // round to nearest (ties up) and add position in one sum, then shift
   always_comb begin
      sum_x = widen(p_xc_ff) - widen(p_ys_ff)
            + {{(SUM_W-COORD_W-FRAC_W){pose_ff.pos_x[COORD_W-1]}}, pose_ff.pos_x,
               {FRAC_W{1'b0}}}
            + SUM_W'(32768);
      sum_y = widen(p_xs_ff) + widen(p_yc_ff)
            + {{(SUM_W-COORD_W-FRAC_W){pose_ff.pos_y[COORD_W-1]}}, pose_ff.pos_y,
               {FRAC_W{1'b0}}}
            + SUM_W'(32768);
      s3_in.world_x      = sat_coord(sum_x[SUM_W-1:FRAC_W]);
      s3_in.world_y      = sat_coord(sum_y[SUM_W-1:FRAC_W]);
      s3_in.local_x      = s2_lx_ff;
      s3_in.local_y      = s2_ly_ff;
      s3_in.final_vertex = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= req_if.payload;
         s2_lx_ff   <= s1_ff.vertex_x;
         s2_ly_ff   <= s1_ff.vertex_y;
         s2_last_ff <= s1_ff.final_vertex;
         p_xc_ff    <= s1_ff.vertex_x * pose_ff.cos_angle;
         p_ys_ff    <= s1_ff.vertex_y * pose_ff.sin_angle;
         p_xs_ff    <= s1_ff.vertex_x * pose_ff.sin_angle;
         p_yc_ff    <= s1_ff.vertex_y * pose_ff.cos_angle;
         s3_ff      <= s3_in;
      end
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = s3_ff;

endmodule

FILE: rtl/ppp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties queue
// Short first-in first-out buffer of placed vertices between front and back.
// ----------------------------------------------------------------------------
module ppp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ppp_pkg::world_item_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ppp_pkg::world_item_type pop_data
);
   import ppp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   world_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // move pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ppp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties divider
// Two-lane restoring divider: signed sums over an unsigned count, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module ppp_divider #(
   parameter int DIVISOR_W = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [ppp_pkg::VALUE_W-1:0] dividend_x,
   input  logic signed [ppp_pkg::VALUE_W-1:0] dividend_y,
   input  logic [DIVISOR_W-1:0]              divisor,
   output logic                              done,
   output logic signed [ppp_pkg::VALUE_W-1:0] quotient_x,
   output logic signed [ppp_pkg::VALUE_W-1:0] quotient_y
);
   import ppp_pkg::*;

   localparam int STEP_W = $clog2(VALUE_W + 1);

   logic [VALUE_W-1:0]   quo_ff [2];
   logic [VALUE_W-1:0]   quo_in [2];
   logic [DIVISOR_W-1:0] rem_ff [2];
   logic [DIVISOR_W-1:0] rem_in [2];
   logic                 neg_ff [2];
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial [2];
   logic signed [VALUE_W-1:0] dividend [2];

   assign dividend[0] = dividend_x;
   assign dividend[1] = dividend_y;

   // one restoring step per lane
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][VALUE_W-1]};
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         if (step_ff != '0) begin
            if (trial[i] >= {1'b0, divisor_ff}) begin
               rem_in[i] = DIVISOR_W'(trial[i] - {1'b0, divisor_ff});
               quo_in[i] = {quo_ff[i][VALUE_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][DIVISOR_W-1:0];
               quo_in[i] = {quo_ff[i][VALUE_W-2:0], 1'b0};
            end
         end
      end
      step_in = (step_ff != '0) ? step_ff - 1'b1 : step_ff;
      done_in = done_ff || (step_ff == STEP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= STEP_W'(VALUE_W);
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // load magnitudes on start, then iterate
   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         for (int i = 0; i < 2; i++) begin
            neg_ff[i] <= dividend[i][VALUE_W-1];
            quo_ff[i] <= dividend[i][VALUE_W-1] ? VALUE_W'(-dividend[i])
                                               : VALUE_W'(dividend[i]);
            rem_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 2; i++) begin
            quo_ff[i] <= quo_in[i];
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign done       = done_ff;
   assign quotient_x = neg_ff[0] ? VALUE_W'(-quo_ff[0]) : VALUE_W'(quo_ff[0]);
   assign quotient_y = neg_ff[1] ? VALUE_W'(-quo_ff[1]) : VALUE_W'(quo_ff[1]);

endmodule

FILE: rtl/ppp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon pose properties back end
// Takes placed vertices from the queue, emits vertices and edges, keeps the
// run accumulators and, on the final vertex, emits the polygon summary.
// ----------------------------------------------------------------------------
module ppp_back #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  ppp_pkg::world_item_type pop_data,
   ppp_stream_if.source            rsp_if
);
   import ppp_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
   localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

   back_state_type state_ff, state_in;

   world_item_type            cur_ff;
   logic signed [COORD_W-1:0] prev_wx_ff, prev_wy_ff, first_wx_ff, first_wy_ff;
   logic signed [COORD_W-1:0] prev_lx_ff, prev_ly_ff, first_lx_ff, first_ly_ff;
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic signed [VALUE_W-1:0] sum_x_ff, sum_y_ff;
   logic signed [AREA_W-1:0]  area_ff, prod_a_ff, prod_b_ff;
   logic [AREA_W-1:0]         mag_ff, rounded;
   logic [VALUE_W-1:0]        area_res_ff;
   logic [CNT_W-1:0]          count_ff;

   logic signed [COORD_W-1:0] mul_a1, mul_a2, mul_b1, mul_b2;
   logic                      use_first, rsp_fire, rsp_valid, div_start, div_done;
   logic signed [VALUE_W-1:0] cent_x, cent_y;
   result_type                rsp;

   function automatic logic signed [AREA_W-1:0] sat_add64(
      input logic signed [AREA_W-1:0] a, input logic signed [AREA_W-1:0] b);
      logic signed [AREA_W:0] s;
      s = {a[AREA_W-1], a} + {b[AREA_W-1], b};
      if (s[AREA_W] != s[AREA_W-1]) begin
         sat_add64 = s[AREA_W] ? AREA_MIN : AREA_MAX;
      end else begin
         sat_add64 = s[AREA_W-1:0];
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat_sum(
      input logic signed [VALUE_W-1:0] a, input logic signed [COORD_W-1:0] b);
      logic signed [VALUE_W:0] s;
      s = {a[VALUE_W-1], a} + {{(VALUE_W-COORD_W+1){b[COORD_W-1]}}, b};
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         sat_sum = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                              : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         sat_sum = s[VALUE_W-1:0];
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] wide_diff(
      input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      wide_diff = {{(VALUE_W-COORD_W-1){d[COORD_W]}}, d};
   endfunction

   function automatic logic signed [VALUE_W-1:0] wide(input logic signed [COORD_W-1:0] a);
      wide = {{(VALUE_W-COORD_W){a[COORD_W-1]}}, a};
   endfunction

   assign rsp_fire = rsp_valid && rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (pop_valid) state_in = ST_VERT;
         ST_VERT: begin
            if (rsp_fire) state_in = (count_ff == '0) ? ST_UPDATE : ST_EDGE;
         end
         ST_EDGE:      if (rsp_fire) state_in = ST_AREA1;
         ST_AREA1:     state_in = ST_AREA2;
         ST_AREA2:     state_in = ST_UPDATE;
         ST_UPDATE:    state_in = cur_ff.final_vertex ? ST_FIN_START : ST_IDLE;
         ST_FIN_START: state_in = ST_CLOSE;
         ST_CLOSE:     if (rsp_fire) state_in = ST_CACC1;
         ST_CACC1:     state_in = ST_CACC2;
         ST_CACC2:     state_in = ST_CMAG;
         ST_CMAG:      state_in = ST_CROUND;
         ST_CROUND:    state_in = ST_CENT;
         ST_CENT:      if (rsp_fire) state_in = ST_ORIGIN;
         ST_ORIGIN:    if (rsp_fire) state_in = ST_SIZE;
         ST_SIZE:      if (rsp_fire) state_in = ST_AREA;
         ST_AREA:      if (rsp_fire) state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs per state
   always_comb begin
      pop_ready   = 1'b0;
      div_start   = 1'b0;
      rsp_valid   = 1'b0;
      rsp.kind    = KIND_VERTEX;
      rsp.value_x = wide(cur_ff.world_x);
      rsp.value_y = wide(cur_ff.world_y);
      rsp.run_end = 1'b0;
      unique case (state_ff)
         ST_IDLE:      pop_ready = 1'b1;
         ST_VERT: begin
            rsp_valid   = 1'b1;
            rsp.run_end = (count_ff == '0) && !cur_ff.final_vertex;
         end
         ST_EDGE: begin
            rsp_valid   = 1'b1;
            rsp.kind    = KIND_EDGE;
            rsp.value_x = wide_diff(cur_ff.world_x, prev_wx_ff);
            rsp.value_y = wide_diff(cur_ff.world_y, prev_wy_ff);
            rsp.run_end = !cur_ff.final_vertex;
         end
         ST_FIN_START: div_start = 1'b1;
         ST_CLOSE: begin
            rsp_valid   = 1'b1;
            rsp.kind    = KIND_EDGE;
            rsp.value_x = wide_diff(first_wx_ff, cur_ff.world_x);
            rsp.value_y = wide_diff(first_wy_ff, cur_ff.world_y);
         end
         ST_CENT: begin
            rsp_valid   = div_done;
            rsp.kind    = KIND_CENTROID;
            rsp.value_x = cent_x;
            rsp.value_y = cent_y;
         end
         ST_ORIGIN: begin
            rsp_valid   = 1'b1;
            rsp.kind    = KIND_BOX_ORIGIN;
            rsp.value_x = wide(min_x_ff);
            rsp.value_y = wide(min_y_ff);
         end
         ST_SIZE: begin
            rsp_valid   = 1'b1;
            rsp.kind    = KIND_BOX_SIZE;
            rsp.value_x = wide_diff(max_x_ff, min_x_ff);
            rsp.value_y = wide_diff(max_y_ff, min_y_ff);
         end
         ST_AREA: begin
            rsp_valid   = 1'b1;
            rsp.kind    = KIND_AREA;
            rsp.value_x = area_res_ff;
            rsp.value_y = '0;
            rsp.run_end = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp;

   // cross products: run terms, or the closing term once the run ends
   assign use_first = (state_ff == ST_FIN_START) || (state_ff == ST_CLOSE) ||
                      (state_ff == ST_CACC1) || (state_ff == ST_CACC2);
   assign mul_a1 = use_first ? first_lx_ff    : cur_ff.local_x;
   assign mul_a2 = use_first ? cur_ff.local_y : prev_ly_ff;
   assign mul_b1 = use_first ? cur_ff.local_x : prev_lx_ff;
   assign mul_b2 = use_first ? first_ly_ff    : cur_ff.local_y;

   always_ff @(posedge clock) begin
      prod_a_ff <= mul_a1 * mul_a2;
      prod_b_ff <= mul_b1 * mul_b2;
   end

   assign rounded = mag_ff + AREA_W'(65536);

   // run accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_wx_ff  <= '0;
         prev_wy_ff  <= '0;
         first_wx_ff <= '0;
         first_wy_ff <= '0;
         prev_lx_ff  <= '0;
         prev_ly_ff  <= '0;
         first_lx_ff <= '0;
         first_ly_ff <= '0;
         area_ff     <= '0;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         min_x_ff    <= COORD_MAX;
         min_y_ff    <= COORD_MAX;
         max_x_ff    <= COORD_MIN;
         max_y_ff    <= COORD_MIN;
         count_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_AREA1, ST_CACC1: area_ff <= sat_add64(area_ff, prod_a_ff);
            ST_AREA2, ST_CACC2: area_ff <= sat_add64(area_ff, -prod_b_ff);
            ST_UPDATE: begin
               if (count_ff == '0) begin
                  first_wx_ff <= cur_ff.world_x;
                  first_wy_ff <= cur_ff.world_y;
                  first_lx_ff <= cur_ff.local_x;
                  first_ly_ff <= cur_ff.local_y;
               end
               prev_wx_ff <= cur_ff.world_x;
               prev_wy_ff <= cur_ff.world_y;
               prev_lx_ff <= cur_ff.local_x;
               prev_ly_ff <= cur_ff.local_y;
               sum_x_ff   <= sat_sum(sum_x_ff, cur_ff.world_x);
               sum_y_ff   <= sat_sum(sum_y_ff, cur_ff.world_y);
               if (cur_ff.world_x < min_x_ff) min_x_ff <= cur_ff.world_x;
               if (cur_ff.world_y < min_y_ff) min_y_ff <= cur_ff.world_y;
               if (cur_ff.world_x > max_x_ff) max_x_ff <= cur_ff.world_x;
               if (cur_ff.world_y > max_y_ff) max_y_ff <= cur_ff.world_y;
               if (count_ff != CNT_W'(MAX_VERTICES)) count_ff <= count_ff + 1'b1;
            end
            ST_AREA: begin
               // clear the run once the summary is taken
               if (rsp_fire) begin
                  prev_wx_ff  <= '0;
                  prev_wy_ff  <= '0;
                  first_wx_ff <= '0;
                  first_wy_ff <= '0;
                  prev_lx_ff  <= '0;
                  prev_ly_ff  <= '0;
                  first_lx_ff <= '0;
                  first_ly_ff <= '0;
                  area_ff     <= '0;
                  sum_x_ff    <= '0;
                  sum_y_ff    <= '0;
                  min_x_ff    <= COORD_MAX;
                  min_y_ff    <= COORD_MAX;
                  max_x_ff    <= COORD_MIN;
                  max_y_ff    <= COORD_MIN;
                  count_ff    <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // current vertex and area magnitude pipeline
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         cur_ff <= pop_data;
      end
      if (state_ff == ST_CMAG) begin
         if (area_ff == AREA_MIN) begin
            mag_ff <= AREA_MAX;
         end else begin
            mag_ff <= area_ff[AREA_W-1] ? -area_ff : area_ff;
         end
      end
      if (state_ff == ST_CROUND) begin
         area_res_ff <= VALUE_W'(rounded[AREA_W-1:17]);
      end
   end

   ppp_divider #(
      .DIVISOR_W (CNT_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (sum_x_ff),
      .dividend_y (sum_y_ff),
      .divisor    (count_ff),
      .done       (div_done),
      .quotient_x (cent_x),
      .quotient_y (cent_y)
   );

endmodule

FILE: rtl/polygon_pose_properties.sv
`timescale 1ns / 1ps
// Path: a world vertex passes the 3 placement stages, the queue and the back-end
//   load. The back end loads, emits and records each vertex; a later vertex also
//   emits its edge and adds to the area, and a final vertex adds the closing edge
//   and summary, the centroid from the 48-step divider. The 3-stage front takes
//   items while the back end works, if the queue has room. Reset is synchronous,
//   active high: pose returns to identity and all run accumulators clear at once.
// ----------------------------------------------------------------------------
// Polygon pose properties
// Places local polygon vertices in the world and emits vertices, edges,
// centroid, bounding box and shoelace area.
// ----------------------------------------------------------------------------
module polygon_pose_properties #(
   parameter int MAX_VERTICES = 64,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ppp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   ppp_stream_if.sink                      req_if,
   ppp_stream_if.source                    rsp_if
);
   import ppp_pkg::*;

   logic           push_valid, push_ready, pop_valid, pop_ready;
   world_item_type push_data, pop_data;

   ppp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ppp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ppp_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule
